>>> rtl/kss_pkg.sv
// kss_pkg: shared constants and control/status structs for the rank selector.
// Used by kss_ctrl, kss_dp and kth_smallest_select_unit.
package kss_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int DATA_W           = 32;  // width of the value ports
  localparam int RANK_W           = 6;

  // controller -> datapath
  typedef struct packed {
    logic wr;        // input beat taken: store value, latch rank
    logic clr;       // start a new set
    logic j_clr;
    logic j_inc;
    logic cand_rd;   // read candidate at j
    logic cand_ld;   // capture candidate, clear tallies
    logic k_clr;
    logic scan_rd;   // read element at k, advance k
    logic res_ld;    // result = candidate, valid
    logic res_fail;  // result = 0, invalid
  } kss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fail;      // overflowed set or rank out of range
    logic last_k;    // scan read address is the final element
    logic hit;       // candidate sits at the wanted rank
  } kss_sts_t;

endpackage

>>> rtl/kss_dp.sv
// kss_dp: element memory, candidate register, scan tallies and result register.
// Depends on kss_pkg; sequenced by kss_ctrl.
module kss_dp import kss_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kss_cmd_t          cmd,
  output kss_sts_t          sts,
  input  logic [DATA_W-1:0] in_value,
  input  logic [RANK_W-1:0] in_rank,
  output logic [DATA_W-1:0] out_selected,
  output logic              out_valid_res
);

  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

  logic [CW-1:0]          count_r;
  logic                   ovf_r;
  logic [RANK_W-1:0]      rank_r;
  logic [AW-1:0]          j_r;
  logic [AW-1:0]          k_r;
  logic [VALUE_WIDTH-1:0] cand_r;
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   pend_r;
  logic [CW-1:0]          below_r;
  logic [CW-1:0]          upto_r;
  logic [VALUE_WIDTH-1:0] sel_r;
  logic                   ok_r;

  logic                          full;
  logic [AW-1:0]                 rd_addr;
  logic [VALUE_WIDTH+DATA_W-1:0] in_ext;
  logic [VALUE_WIDTH+DATA_W-1:0] out_ext;
  logic [VALUE_WIDTH-1:0]        wr_data;
  logic                          lt;
  logic                          le;
  logic [CMPW-1:0]               rank_x;
  logic [CMPW-1:0]               count_x;
  logic [CMPW-1:0]               below_x;
  logic [CMPW-1:0]               upto_x;
  logic [CW-1:0]                 k_x;

  // value port is zero-extended or truncated to the element width
  assign in_ext  = {{VALUE_WIDTH{1'b0}}, in_value};
  assign wr_data = in_ext[VALUE_WIDTH-1:0];
  assign out_ext = {{DATA_W{1'b0}}, sel_r};

  assign full    = (count_r == CW'(MAX_ELEMENTS));
  assign rd_addr = cmd.scan_rd ? k_r : j_r;

  assign lt = $signed(rd_data_r) <  $signed(cand_r);
  assign le = $signed(rd_data_r) <= $signed(cand_r);

  assign rank_x  = CMPW'(rank_r);
  assign count_x = CMPW'(count_r);
  assign below_x = CMPW'(below_r);
  assign upto_x  = CMPW'(upto_r);
  assign k_x     = CW'(k_r);

  assign sts.fail   = ovf_r || (rank_x >= count_x);
  assign sts.last_k = (k_x == count_r - CW'(1));
  assign sts.hit    = (below_x <= rank_x) && (rank_x < upto_x);

  assign out_selected  = out_ext[DATA_W-1:0];
  assign out_valid_res = ok_r;

  always_ff @(posedge clk) begin
    if (cmd.wr && !full) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    if (cmd.cand_rd || cmd.scan_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cmd.scan_rd;
      if (cmd.clr) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.wr) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      rank_r <= in_rank;
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + AW'(1);
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.scan_rd) begin
      k_r <= k_r + AW'(1);
    end
    if (cmd.cand_ld) begin
      cand_r  <= rd_data_r;
      below_r <= '0;
      upto_r  <= '0;
    end else if (pend_r) begin
      below_r <= below_r + CW'(lt);
      upto_r  <= upto_r + CW'(le);
    end
    if (cmd.res_ld) begin
      sel_r <= cand_r;
      ok_r  <= 1'b1;
    end else if (cmd.res_fail) begin
      sel_r <= '0;
      ok_r  <= 1'b0;
    end
  end

  // element count can never pass the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_tally_order: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> below_r <= upto_r)
    else $error("below tally exceeds upto tally");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> ok_r)
    else $error("result loaded without valid flag");

endmodule

>>> rtl/kss_ctrl.sv
// kss_ctrl: sequencer for load, candidate fetch, scan and result hand-off.
// Depends on kss_pkg; drives kss_dp through kss_cmd_t.
module kss_ctrl import kss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output kss_cmd_t cmd,
  input  kss_sts_t sts
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_CAND_RD,
    S_CAND_LD,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_acc;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.wr = in_acc;
        if (in_acc && in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.fail) begin
          cmd.res_fail = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.j_clr = 1'b1;
          state_nxt = S_CAND_RD;
        end
      end
      S_CAND_RD: begin
        cmd.cand_rd = 1'b1;
        state_nxt   = S_CAND_LD;
      end
      S_CAND_LD: begin
        cmd.cand_ld = 1'b1;
        cmd.k_clr   = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.last_k) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read beat lands in the tallies
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_CAND_RD;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.clr   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_load_in_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (state_r == S_START))
    else $error("last beat did not start selection");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_START || $past(state_r) == S_CHECK))
    else $error("result raised from unexpected state");

endmodule

>>> rtl/kth_smallest_select_unit.sv
// Rank selector: beats load one per cycle while in_stall is low; after the last beat,
// each candidate j goes through fetch, capture, memory scan, drain and check, with
// one memory read port. Out-of-range rank or overflowed set: the start state skips
// the scan and raises out_valid with an invalid result. Input stalls until the
// result beat is taken. Synchronous active-low reset empties the set.
module kth_smallest_select_unit import kss_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_value,
  input  logic [RANK_W-1:0] in_rank,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_selected,
  output logic              out_valid_res
);

  kss_cmd_t cmd;
  kss_sts_t sts;

  kss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  kss_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .in_rank       (in_rank),
    .out_selected  (out_selected),
    .out_valid_res (out_valid_res)
  );

endmodule

>>> sim/kth_smallest_select_unit_tb.sv
// Testbench for kth_smallest_select_unit: loads signed sets, asks for a rank and
// checks each selected element against an in-bench sorting predictor.
// Depends on rtl/kss_pkg.sv and rtl/kth_smallest_select_unit.sv.
`timescale 1ns / 1ps

module kth_smallest_select_unit_tb;
  import kss_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // worst selection: every candidate scans the whole full set
  localparam int SETTLE_CYCLES = MAX_ELEMENTS_DEF * (MAX_ELEMENTS_DEF + 4) + 16;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [DATA_W-1:0] selected;
    logic              valid_res;
  } pick_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] in_value      = '0;
  logic [RANK_W-1:0] in_rank       = '0;
  logic              in_last       = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [DATA_W-1:0] out_selected;
  logic              out_valid_res;

  // predictor copy of the set being loaded
  logic signed [DATA_W-1:0] held_values [MAX_ELEMENTS_DEF];
  int                       held_count    = 0;
  bit                       held_overflow = 1'b0;

  pick_t             pending_picks[$];
  logic [DATA_W-1:0] set_buf[$];

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int stall_left = 0;
  int beats_sent = 0;
  int sets_sent = 0;
  int sets_rejected = 0;
  int sets_overflowed = 0;
  int results_seen = 0;
  int failures = 0;
  int cycle_count = 0;

  kth_smallest_select_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_rank      (in_rank),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_selected (out_selected),
    .out_valid_res(out_valid_res)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_picks.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic log_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Element at the wanted rank of the held set, sorted ascending as signed values.
  function automatic pick_t pick_ranked(input int want);
    logic signed [DATA_W-1:0] sorted [MAX_ELEMENTS_DEF];
    logic signed [DATA_W-1:0] key;
    int i, j;
    pick_t r;
    r.selected  = '0;
    r.valid_res = 1'b0;
    if (held_overflow || want >= held_count) begin
      return r;
    end
    for (i = 0; i < held_count; i++) begin
      sorted[i] = held_values[i];
    end
    for (i = 1; i < held_count; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    r.selected  = sorted[want];
    r.valid_res = 1'b1;
    return r;
  endfunction

  function automatic void record_beat(input logic [DATA_W-1:0] value,
                                      input logic [RANK_W-1:0] rank, input logic last);
    pick_t r;
    if (held_count < MAX_ELEMENTS_DEF) begin
      held_values[held_count] = value;
      held_count++;
    end else begin
      held_overflow = 1'b1;  // beat dropped, the last one included
    end
    if (last) begin
      r = pick_ranked(int'(rank));
      pending_picks.insert(pending_picks.size(), r);
      sets_sent++;
      if (held_overflow) sets_overflowed++;
      if (!r.valid_res) sets_rejected++;
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  task automatic send_beat(input logic [DATA_W-1:0] value, input logic [RANK_W-1:0] rank,
                           input logic last);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_rank  <= rank;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
    record_beat(value, rank, last);
    beats_sent++;
  endtask

  // Sends set_buf; the rank rides on the final beat, noise on the others.
  task automatic send_set(input logic [RANK_W-1:0] rank);
    int n;
    for (n = 0; n < set_buf.size(); n++) begin
      if (n == set_buf.size() - 1) begin
        send_beat(set_buf[n], rank, 1'b1);
      end else begin
        send_beat(set_buf[n], RANK_W'($urandom_range(0, 63)), 1'b0);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return DATA_W'($urandom_range(0, 6)) - 3;  // narrow pool forces duplicates
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_sets(input int beat_goal);
    int size, pick, n, top, stop_at;
    logic [RANK_W-1:0] rank;
    stop_at = beats_sent + beat_goal;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) size = $urandom_range(1, 10);
      else if (pick < 90) size = $urandom_range(11, 40);
      else if (pick < 95) size = MAX_ELEMENTS_DEF;
      else size = $urandom_range(MAX_ELEMENTS_DEF + 1, MAX_ELEMENTS_DEF + 8);
      set_buf.delete();
      for (n = 0; n < size; n++) begin
        set_buf.insert(set_buf.size(), draw_value());
      end
      top  = (size < MAX_ELEMENTS_DEF) ? size : MAX_ELEMENTS_DEF;
      pick = $urandom_range(0, 19);
      if (size == MAX_ELEMENTS_DEF && pick < 6) begin
        rank = (pick < 3) ? RANK_W'(MAX_ELEMENTS_DEF - 1) : '0;
      end else if (pick < 17) begin
        rank = RANK_W'($urandom_range(0, top - 1));
      end else begin
        rank = RANK_W'($urandom_range(0, 63));
      end
      send_set(rank);
    end
  endtask

  task automatic test_directed();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_buf = {32'h7FFF_FFFF};
    send_set(6'd0);                                   // one-element set
    set_buf = {32'h8000_0000};
    send_set(6'd1);                                   // rank just past the count
    set_buf = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    send_set(6'd0);
    send_set(6'd4);
    set_buf = {32'd7, 32'hFFFF_FFFE, 32'd7, 32'd7};
    send_set(6'd2);                                   // duplicates counted
    set_buf = {32'd3, 32'd3};
    send_set(6'h3F);
    set_buf = {32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0};
    send_set(6'h01);
  endtask

  task automatic test_idle_random();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    run_random_sets(1100);
  endtask

  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_random_sets(300);
  endtask

  task automatic test_one_sided_idle();
    send_idle = 1'b1;
    recv_idle = 1'b0;
    run_random_sets(100);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    run_random_sets(100);
  endtask

  // Result side: stall drawn per beat, counted down while a result is offered.
  always @(posedge clk) begin : result_check
    pick_t due;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_picks.size() == 0) begin
          log_failure($sformatf("unexpected result: selected=%0d valid_res=%0b",
                                $signed(out_selected), out_valid_res));
        end else begin
          due = pending_picks.pop_front();
          if (out_selected !== due.selected || out_valid_res !== due.valid_res) begin
            log_failure($sformatf("result %0d: expected selected=%0d valid_res=%0b, got %0d %0b",
                                  results_seen, $signed(due.selected), due.valid_res,
                                  $signed(out_selected), out_valid_res));
          end
        end
        stall_left = recv_idle ? $urandom_range(0, 7) : 0;
      end else if (out_valid && stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_idle_random();
    test_back_to_back();
    test_one_sided_idle();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_picks.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", pending_picks.size()));
    end
    $display("Loaded %0d beats in %0d sets; %0d results checked", beats_sent, sets_sent,
             results_seen);
    $display("Rejected sets: %0d (overflowed %0d), failures: %0d", sets_rejected,
             sets_overflowed, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
